// ----- src/b64d_pkg.sv -----
// Shared types, constants and the character classifier for the base64 decoder.
// No dependencies; every other file of the block uses it by scoped names.
package b64d_pkg;

  // Width of the running byte counter and of the capacity comparisons.
  localparam int COUNT_WIDTH = 16;
  localparam int SUM_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = FIFO_AW + 1;

  // Reset value of the capacity register.
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // Symbol codes beyond the 64 alphabet values.
  localparam logic [6:0] SYM_SKIP = 7'd64;
  localparam logic [6:0] SYM_PAD = 7'd65;
  localparam logic [6:0] SYM_BAD = 7'd66;

  // Command codes.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_FULL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t kind;
    logic [15:0] out_count;
    logic last;
  } result_t;

  // Items handed to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    result_t [2:0] item;
  } push_req_t;

  // Map a character byte onto its sextet value or a symbol code.
  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] sym;
    sym = SYM_BAD;
    if (c inside {[8'h41:8'h5A]}) begin
      sym = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      sym = 7'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      sym = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      sym = 7'd62;
    end else if (c == 8'h2F) begin
      sym = 7'd63;
    end else if (c == 8'h0A) begin
      sym = SYM_SKIP;
    end else if (c == 8'h3D) begin
      sym = SYM_PAD;
    end
    return sym;
  endfunction

  // Low 16 bits of a wide count, as shown on the out_count field.
  function automatic logic [15:0] count16(input logic [SUM_W-1:0] v);
    return v[15:0];
  endfunction

endpackage

// ----- src/b64d_out_fifo.sv -----
// Output queue of the base64 decoder: takes up to three items a cycle and
// hands them out one per cycle while pop is asserted. Depends on b64d_pkg.
module b64d_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  b64d_pkg::push_req_t        push,
  input  logic                       pop,
  output logic                       room,
  output logic                       nonempty,
  output b64d_pkg::result_t          head
);

  b64d_pkg::result_t mem [b64d_pkg::FIFO_DEPTH];
  logic [b64d_pkg::FIFO_AW-1:0] wr_ptr;
  logic [b64d_pkg::FIFO_AW-1:0] rd_ptr;
  logic [b64d_pkg::FIFO_CW-1:0] count;
  logic [b64d_pkg::FIFO_CW-1:0] count_next;

  // Room for a full group of three regardless of what leaves this cycle.
  assign room = count <= b64d_pkg::FIFO_CW'(b64d_pkg::FIFO_DEPTH - 3);
  assign nonempty = count != '0;
  assign head = mem[rd_ptr];

  assign count_next = count + b64d_pkg::FIFO_CW'(push.n) - b64d_pkg::FIFO_CW'(pop);

  // Storage: the pushed items go to consecutive slots after the write pointer.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.n) begin
        mem[b64d_pkg::FIFO_AW'(wr_ptr + b64d_pkg::FIFO_AW'(k))] <= push.item[k];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= b64d_pkg::FIFO_AW'(wr_ptr + b64d_pkg::FIFO_AW'(push.n));
      rd_ptr <= b64d_pkg::FIFO_AW'(rd_ptr + b64d_pkg::FIFO_AW'(pop));
      count <= count_next;
    end
  end

endmodule

// ----- src/base64_decoder_unit.sv -----
// An accepted item is held in the input register and decoded from there; its
// results go to the output queue and are offered from its head.
// Throughput: one item per cycle while the eight-entry output queue has room
// for three results; a stream never yields more results than items, so only
// output stalls hold the input back. Reset (rst, synchronous) empties the
// queue, clears the stream state and sets the capacity register to 65535.
// Top level of the base64 decoder; depends on b64d_pkg and b64d_out_fifo.
module base64_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [15:0] out_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = b64d_pkg::COUNT_WIDTH;
  localparam int SW = b64d_pkg::SUM_W;

  // Configuration and stream state.
  logic [15:0]   out_capacity;
  logic [17:0]   acc, acc_next;
  logic [1:0]    sext_cnt, sext_cnt_next;
  logic          pad_seen, pad_seen_next;
  logic          error_seen, error_seen_next;
  logic [CW-1:0] byte_count, byte_count_next;

  // Input register.
  logic       in_reg_valid;
  logic       in_reg_cmd;
  logic [7:0] in_reg_char;

  logic                   room;
  logic                   decode_en;
  logic                   accept;
  logic [6:0]             sym;
  logic [SW-1:0]          cap_w, bc_w, p1, p2, p3;
  b64d_pkg::push_req_t    push;
  b64d_pkg::result_t      head;

  assign cfg_ready = 1'b1;
  assign decode_en = in_reg_valid && room;
  assign in_stall = in_reg_valid && !room;
  assign accept = in_valid && !in_stall;

  assign sym = b64d_pkg::classify(in_reg_char);
  assign cap_w = SW'(out_capacity);
  assign bc_w = SW'(byte_count);
  assign p1 = bc_w + SW'(1);
  assign p2 = bc_w + SW'(2);
  assign p3 = bc_w + SW'(3);

  // Decode of the item in the input register against the stream state.
  always_comb begin
    logic [1:0]    idx;
    logic [CW-1:0] bc_after;
    logic [23:0]   group;
    logic          tail_full;

    acc_next = acc;
    sext_cnt_next = sext_cnt;
    pad_seen_next = pad_seen;
    error_seen_next = error_seen;
    byte_count_next = byte_count;
    push = '0;
    idx = 2'd0;
    bc_after = byte_count;
    group = {acc, sym[5:0]};
    tail_full = 1'b0;

    if (decode_en) begin
      if (in_reg_cmd == b64d_pkg::CMD_END) begin
        // End of stream: unless an error was reported, flush the tail and report; then start afresh.
        acc_next = '0;
        sext_cnt_next = '0;
        pad_seen_next = 1'b0;
        error_seen_next = 1'b0;
        byte_count_next = '0;
        if (!error_seen) begin
          if (sext_cnt == 2'd3) begin
            if (p2 > cap_w) begin
              tail_full = 1'b1;
              push.item[0] = '{8'd0, b64d_pkg::KIND_FULL, b64d_pkg::count16(p2), 1'b1};
              push.n = 2'd1;
            end else begin
              push.item[0] = '{acc[17:10], b64d_pkg::KIND_DATA,
                               b64d_pkg::count16(SW'(p1[CW-1:0])), 1'b0};
              push.item[1] = '{acc[9:2], b64d_pkg::KIND_DATA,
                               b64d_pkg::count16(SW'(p2[CW-1:0])), 1'b0};
              bc_after = p2[CW-1:0];
              idx = 2'd2;
            end
          end else if (sext_cnt == 2'd2) begin
            if (p1 > cap_w) begin
              tail_full = 1'b1;
              push.item[0] = '{8'd0, b64d_pkg::KIND_FULL, b64d_pkg::count16(p1), 1'b1};
              push.n = 2'd1;
            end else begin
              push.item[0] = '{acc[11:4], b64d_pkg::KIND_DATA,
                               b64d_pkg::count16(SW'(p1[CW-1:0])), 1'b0};
              bc_after = p1[CW-1:0];
              idx = 2'd1;
            end
          end
          // Closing item: the terminator slot must still fit.
          if (!tail_full) begin
            if (SW'(bc_after) + SW'(1) > cap_w) begin
              push.item[idx] = '{8'd0, b64d_pkg::KIND_FULL,
                                 b64d_pkg::count16(SW'(bc_after)), 1'b1};
            end else begin
              push.item[idx] = '{8'd0, b64d_pkg::KIND_END,
                                 b64d_pkg::count16(SW'(bc_after)), 1'b1};
            end
            push.n = 2'(idx + 2'd1);
          end
        end
      end else if (!error_seen && !pad_seen) begin
        case (sym)
          b64d_pkg::SYM_SKIP: begin
          end
          b64d_pkg::SYM_PAD: begin
            pad_seen_next = 1'b1;
          end
          b64d_pkg::SYM_BAD: begin
            error_seen_next = 1'b1;
            push.item[0] = '{8'd0, b64d_pkg::KIND_INVALID,
                             b64d_pkg::count16(bc_w), 1'b1};
            push.n = 2'd1;
          end
          default: begin
            if (sext_cnt != 2'd3) begin
              acc_next = {acc[11:0], sym[5:0]};
              sext_cnt_next = sext_cnt + 2'd1;
            end else begin
              // Fourth sextet completes a group of three bytes.
              acc_next = '0;
              sext_cnt_next = '0;
              if (p3 > cap_w) begin
                error_seen_next = 1'b1;
                byte_count_next = p3[CW-1:0];
                push.item[0] = '{8'd0, b64d_pkg::KIND_FULL, b64d_pkg::count16(p3), 1'b1};
                push.n = 2'd1;
              end else begin
                byte_count_next = p3[CW-1:0];
                push.item[0] = '{group[23:16], b64d_pkg::KIND_DATA,
                                 b64d_pkg::count16(SW'(p1[CW-1:0])), 1'b0};
                push.item[1] = '{group[15:8], b64d_pkg::KIND_DATA,
                                 b64d_pkg::count16(SW'(p2[CW-1:0])), 1'b0};
                push.item[2] = '{group[7:0], b64d_pkg::KIND_DATA,
                                 b64d_pkg::count16(SW'(p3[CW-1:0])), 1'b0};
                push.n = 2'd3;
              end
            end
          end
        endcase
      end
    end
  end

  // State, configuration and input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= b64d_pkg::CAP_RESET;
      acc <= '0;
      sext_cnt <= '0;
      pad_seen <= 1'b0;
      error_seen <= 1'b0;
      byte_count <= '0;
      in_reg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_capacity <= cfg_data;
      end
      acc <= acc_next;
      sext_cnt <= sext_cnt_next;
      pad_seen <= pad_seen_next;
      error_seen <= error_seen_next;
      byte_count <= byte_count_next;
      if (accept) begin
        in_reg_valid <= 1'b1;
      end else if (decode_en) begin
        in_reg_valid <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg_cmd <= cmd;
      in_reg_char <= char_code;
    end
  end

  b64d_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (out_valid && !out_stall),
    .room     (room),
    .nonempty (out_valid),
    .head     (head)
  );

  assign out_byte = head.out_byte;
  assign kind = head.kind;
  assign out_count = head.out_count;
  assign last = head.last;

endmodule

// ----- src/b64d_checker.sv -----
// Port-level checks for the base64 decoder, bound to its top level.
// Depends on b64d_pkg and on the ports of base64_decoder_unit.
module b64d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  kind,
  input logic [15:0] out_count,
  input logic        last
);

  // A stalled result item holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(out_count) && $stable(last))
    else $error("stalled result item changed");

  // Data items never close a stream, status items always do.
  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == b64d_pkg::KIND_DATA |-> !last)
    else $error("data item marked last");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != b64d_pkg::KIND_DATA |-> last && out_byte == 8'd0)
    else $error("status item not last or carries a byte");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind base64_decoder_unit b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .kind      (kind),
  .out_count (out_count),
  .last      (last)
);
